// File: rtl/core/rcf_pkg.sv
// route corridor cost floor: shared types, codes and constants
// no dependencies
`default_nettype none
package rcf_pkg;

  localparam int MAX_SEGMENTS_DEF    = 64;
  localparam int CELL_INDEX_BITS_DEF = 12;
  localparam int COORD_FRAC_BITS     = 16;
  localparam int OUT_IDX_BITS        = 12;
  localparam int COST_BITS           = 8;
  localparam int COORD_BITS          = 32;
  localparam int LEN_BITS            = 31;
  localparam int SEG_BITS            = 4 * COORD_BITS;
  localparam int MUL_DIGIT           = 8;

  // 0.05 m rounded at the chosen fraction width
  localparam logic [LEN_BITS-1:0] CELL_SIZE_RESET =
    LEN_BITS'(((64'd5 << COORD_FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_PROCESS = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MIN_COST = 3'd0,
    REG_RADIUS   = 3'd1,
    REG_CELL     = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CX, ST_CY, ST_LIM, ST_FETCH, ST_LOAD, ST_DOT_A, ST_DOT_B,
    ST_LEN_A, ST_LEN_B, ST_RANGE, ST_CRS_A, ST_CRS_B, ST_SQ, ST_RHS, ST_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/route_corridor_cost_floor.sv
// route corridor cost floor, top level
// depends on rcf_pkg, rcf_ram, rcf_mul
//
// input channel: in_valid/in_stall carry one command per transaction.
// clear empties the segment table and add appends one segment (dropped
// when the table is full); both finish in the accepting cycle and give
// no result. process computes the cell centre and tests it against the stored
// segments in order, then one result transaction leaves on out_valid/out_stall.
// process first runs three multiplications of setup for the centre and the
// squared radius, then per stored segment 4 passes through the shared
// multiplier, or 8 when the projection falls inside the segment. a pass
// works through its second operand one byte at a time and ends once no
// nonzero byte is left. the walk stops at the first segment whose corridor
// holds the centre. one command is in work at a time: in_stall is high until
// the sequencer is back to idle. the result sits in an output register, so
// the next command is taken while it waits; a further process result waits
// for that register while out_stall is high.
// reset empties the table, loads register defaults and drops out_valid.
`default_nettype none
module route_corridor_cost_floor
  import rcf_pkg::*;
#(
  parameter int MAX_SEGMENTS    = MAX_SEGMENTS_DEF,
  parameter int CELL_INDEX_BITS = CELL_INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [2:0]                  cfg_index,
  input  wire logic [COORD_BITS-1:0]       cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  command,
  input  wire logic signed [COORD_BITS-1:0] seg_start_x,
  input  wire logic signed [COORD_BITS-1:0] seg_start_y,
  input  wire logic signed [COORD_BITS-1:0] seg_end_x,
  input  wire logic signed [COORD_BITS-1:0] seg_end_y,
  input  wire logic [CELL_INDEX_BITS-1:0]  cell_x,
  input  wire logic [CELL_INDEX_BITS-1:0]  cell_y,
  input  wire logic [COST_BITS-1:0]        cur_cost,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [OUT_IDX_BITS-1:0]          out_cell_x,
  output logic [OUT_IDX_BITS-1:0]          out_cell_y,
  output logic [COST_BITS-1:0]             new_cost,
  output logic                             on_route,
  output logic                             cost_changed
);

  localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam int CXW  = CELL_INDEX_BITS + 34;
  localparam int WXW  = CXW + 1;
  localparam int VW   = COORD_BITS + 2;
  localparam int OPW  = VW + WXW + 1;
  localparam int PW   = 2 * OPW;
  localparam int LIMW = 2 * LEN_BITS + 3;

  // configuration
  logic [COST_BITS-1:0]         cost_floor;
  logic [LEN_BITS-1:0]          radius;
  logic [LEN_BITS-1:0]          cell_size;
  logic signed [COORD_BITS-1:0] org_x;
  logic signed [COORD_BITS-1:0] org_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_floor <= '0;
      radius     <= '0;
      cell_size  <= CELL_SIZE_RESET;
      org_x      <= '0;
      org_y      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_COST: cost_floor <= cfg_data[COST_BITS-1:0];
        REG_RADIUS:   radius     <= cfg_data[LEN_BITS-1:0];
        REG_CELL:     cell_size  <= cfg_data[LEN_BITS-1:0];
        REG_ORIGIN_X: org_x      <= cfg_data;
        REG_ORIGIN_Y: org_y      <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [CNTW-1:0]            seg_count;
  logic [CNTW-1:0]            k;
  logic                       in_acc;
  logic                       out_take;
  logic                       out_load;

  logic [CELL_INDEX_BITS-1:0] mx, my;
  logic [COST_BITS-1:0]       cost_in;
  logic signed [CXW-1:0]      cx, cy;
  logic [LIMW-1:0]            lim;
  logic signed [VW-1:0]       vx, vy;
  logic signed [WXW-1:0]      wx, wy;
  logic signed [PW-1:0]       dot, len2, crs, lhs;
  logic                       hit;

  // ram
  logic                 ram_we;
  logic [SEG_BITS-1:0]  rdata;

  assign ram_we = in_acc && command == CMD_ADD && seg_count < CNTW'(MAX_SEGMENTS);

  rcf_ram #(.WIDTH(SEG_BITS), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seg_count[AW-1:0]),
    .wdata ({seg_start_x, seg_start_y, seg_end_x, seg_end_y}),
    .raddr (k[AW-1:0]),
    .rdata (rdata)
  );

  // multiplier
  logic                   mul_start;
  logic signed [OPW-1:0]  mul_a, mul_b;
  logic                   mul_done;
  logic signed [PW-1:0]   mul_p;

  rcf_mul #(.OPW(OPW), .PW(PW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // segment geometry from the table entry
  logic signed [COORD_BITS-1:0] s_x0, s_y0, s_x1, s_y1;
  logic signed [COORD_BITS:0]   dx, dy;
  logic signed [COORD_BITS:0]   x0_2, y0_2;
  logic signed [VW-1:0]         vx_c, vy_c;
  logic signed [WXW-1:0]        wx_c, wy_c;
  logic signed [CXW-1:0]        prod_cx;
  logic signed [CXW-1:0]        ox2, oy2;
  logic [LEN_BITS-1:0]          rsel;
  logic signed [PW-1:0]         crs_c;
  logic                         range_ok;

  assign s_x0 = rdata[4*COORD_BITS-1:3*COORD_BITS];
  assign s_y0 = rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign s_x1 = rdata[2*COORD_BITS-1:COORD_BITS];
  assign s_y1 = rdata[COORD_BITS-1:0];
  assign dx   = (COORD_BITS+1)'(s_x1) - (COORD_BITS+1)'(s_x0);
  assign dy   = (COORD_BITS+1)'(s_y1) - (COORD_BITS+1)'(s_y0);
  assign x0_2 = $signed({s_x0, 1'b0});
  assign y0_2 = $signed({s_y0, 1'b0});
  assign vx_c = $signed({dx, 1'b0});
  assign vy_c = $signed({dy, 1'b0});
  assign wx_c = WXW'(cx) - WXW'(x0_2);
  assign wy_c = WXW'(cy) - WXW'(y0_2);

  assign prod_cx = $signed(mul_p[CXW-1:0]);
  assign ox2     = CXW'($signed({org_x, 1'b0}));
  assign oy2     = CXW'($signed({org_y, 1'b0}));
  assign rsel    = (radius == '0) ? cell_size : radius;
  assign crs_c   = crs - mul_p;
  assign range_ok = (len2 != '0) && !dot[PW-1] && (dot <= len2);

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && command == CMD_PROCESS) begin
          mul_start  = 1'b1;
          mul_a      = OPW'({cell_x, 1'b1});
          mul_b      = OPW'(cell_size);
          state_next = ST_CX;
        end
      end
      ST_CX: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'({my, 1'b1});
          mul_b      = OPW'(cell_size);
          state_next = ST_CY;
        end
      end
      ST_CY: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(rsel);
          mul_b      = OPW'(rsel);
          state_next = ST_LIM;
        end
      end
      ST_LIM: begin
        if (mul_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = (k < seg_count) ? ST_LOAD : ST_OUT;
      end
      ST_LOAD: begin
        mul_start  = 1'b1;
        mul_a      = OPW'(vx_c);
        mul_b      = OPW'(wx_c);
        state_next = ST_DOT_A;
      end
      ST_DOT_A: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(vy);
          mul_b      = OPW'(wy);
          state_next = ST_DOT_B;
        end
      end
      ST_DOT_B: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(vx);
          mul_b      = OPW'(vx);
          state_next = ST_LEN_A;
        end
      end
      ST_LEN_A: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(vy);
          mul_b      = OPW'(vy);
          state_next = ST_LEN_B;
        end
      end
      ST_LEN_B: begin
        if (mul_done) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (range_ok) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(vx);
          mul_b      = OPW'(wy);
          state_next = ST_CRS_A;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_CRS_A: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(vy);
          mul_b      = OPW'(wx);
          state_next = ST_CRS_B;
        end
      end
      ST_CRS_B: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = crs_c[OPW-1:0];
          mul_b      = crs_c[OPW-1:0];
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = OPW'(lim);
          mul_b      = len2[OPW-1:0];
          state_next = ST_RHS;
        end
      end
      ST_RHS: begin
        if (mul_done) begin
          state_next = (lhs <= mul_p) ? ST_OUT : ST_FETCH;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count <= '0;
      k         <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc && command == CMD_CLEAR) begin
        seg_count <= '0;
      end else if (ram_we) begin
        seg_count <= seg_count + 1'b1;
      end
      if (state == ST_LIM) begin
        k   <= '0;
        hit <= 1'b0;
      end else if (state == ST_RANGE && !range_ok) begin
        k <= k + 1'b1;
      end else if (state == ST_RHS && mul_done) begin
        if (lhs <= mul_p) begin
          hit <= 1'b1;
        end else begin
          k <= k + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && command == CMD_PROCESS) begin
      mx      <= cell_x;
      my      <= cell_y;
      cost_in <= cur_cost;
    end
    if (mul_done) begin
      unique case (state)
        ST_CX:    cx   <= ox2 + prod_cx;
        ST_CY:    cy   <= oy2 + prod_cx;
        ST_LIM:   lim  <= (radius == '0) ? LIMW'({mul_p[LIMW-2:0], 1'b0})
                                         : LIMW'({mul_p[LIMW-3:0], 2'b00});
        ST_DOT_A: dot  <= mul_p;
        ST_DOT_B: dot  <= dot + mul_p;
        ST_LEN_A: len2 <= mul_p;
        ST_LEN_B: len2 <= len2 + mul_p;
        ST_CRS_A: crs  <= mul_p;
        ST_CRS_B: crs  <= crs_c;
        ST_SQ:    lhs  <= mul_p;
        default: ;
      endcase
    end
    if (state == ST_LOAD) begin
      vx <= vx_c;
      vy <= vy_c;
      wx <= wx_c;
      wy <= wy_c;
    end
    if (out_load) begin
      out_cell_x <= OUT_IDX_BITS'(mx);
      out_cell_y <= OUT_IDX_BITS'(my);
      on_route   <= hit;
      if (!hit && cost_in < cost_floor) begin
        new_cost     <= cost_floor;
        cost_changed <= 1'b1;
      end else begin
        new_cost     <= cost_in;
        cost_changed <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rcf_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module rcf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/rcf_mul.sv
// iterative signed multiplier, one digit of the second operand per cycle
// depends on rcf_pkg
`default_nettype none
module rcf_mul
  import rcf_pkg::*;
#(
  parameter int OPW = 82,
  parameter int PW  = 2 * OPW
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [OPW-1:0] a,
  input  wire logic signed [OPW-1:0] b,
  output logic                       done,
  output logic signed [PW-1:0]       p
);

  logic                   run;
  logic                   neg;
  logic [PW-1:0]          amag;
  logic [OPW-1:0]         bmag;
  logic [PW-1:0]          acc;
  logic [PW+MUL_DIGIT-1:0] pp;
  logic [OPW-1:0]         a_abs;
  logic [OPW-1:0]         b_abs;

  assign a_abs = a[OPW-1] ? (~a + 1'b1) : a;
  assign b_abs = b[OPW-1] ? (~b + 1'b1) : b;
  assign pp    = amag * bmag[MUL_DIGIT-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bmag == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      amag <= PW'(a_abs);
      bmag <= b_abs;
      acc  <= '0;
      neg  <= a[OPW-1] ^ b[OPW-1];
    end else if (run) begin
      if (bmag == '0) begin
        p <= neg ? $signed(~acc + 1'b1) : $signed(acc);
      end else begin
        acc  <= acc + pp[PW-1:0];
        amag <= amag << MUL_DIGIT;
        bmag <= bmag >> MUL_DIGIT;
      end
    end
  end

endmodule
`default_nettype wire
